// ===== hw/rtl/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants and types for the point-to-segment distance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package psd_pkg;

  // Result case codes
  typedef logic [2:0] case_code_t;
  localparam case_code_t CASE_NEAR_START = 3'd0;
  localparam case_code_t CASE_NEAR_END   = 3'd1;
  localparam case_code_t CASE_DEGEN      = 3'd2;
  localparam case_code_t CASE_BEYOND     = 3'd3;
  localparam case_code_t CASE_PERP       = 3'd4;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_START_X  = 3'd0;
  localparam cfg_idx_t REG_START_Y  = 3'd1;
  localparam cfg_idx_t REG_END_X    = 3'd2;
  localparam cfg_idx_t REG_END_Y    = 3'd3;
  localparam cfg_idx_t REG_SNAP_TOL = 3'd4;
  localparam cfg_idx_t REG_DEGEN    = 3'd5;

  // Tolerance register width and reset values
  localparam int TOL_BITS = 16;
  localparam logic [TOL_BITS-1:0] SNAP_TOL_RESET = 16'd7;
  localparam logic [TOL_BITS-1:0] DEGEN_RESET    = 16'd1;

  // Register stages in the front end (diff, multiply, sum, classify)
  localparam int FRONT_LAT = 4;

endpackage

`default_nettype wire

// ===== hw/rtl/psd_delay.sv =====
// ----------------------------------------------------------------------------
// psd_delay
// Fixed-length shift line that advances on enable; keeps sideband aligned.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic [WIDTH-1:0] din,
  output logic      [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] line_r [DEPTH];

  // Shift one place per advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) line_r[i] <= '0;
    end else if (en) begin
      line_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) line_r[i] <= line_r[i-1];
    end
  end

  assign dout = line_r[DEPTH-1];

endmodule

`default_nettype wire

// ===== hw/rtl/psd_front.sv =====
// ----------------------------------------------------------------------------
// psd_front
// Four-stage front end: differences, products, sums, case classification.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_front #(
  parameter int COORD_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic signed [COORD_BITS-1:0]    query_x,
  input  wire logic signed [COORD_BITS-1:0]    query_y,
  input  wire logic signed [COORD_BITS-1:0]    start_x,
  input  wire logic signed [COORD_BITS-1:0]    start_y,
  input  wire logic signed [COORD_BITS-1:0]    end_x,
  input  wire logic signed [COORD_BITS-1:0]    end_y,
  input  wire logic [psd_pkg::TOL_BITS-1:0]    snap_tol,
  input  wire logic [psd_pkg::TOL_BITS-1:0]    degen_len,
  output psd_pkg::case_code_t                  code,
  output logic [2*COORD_BITS:0]                radicand,
  output logic [2*COORD_BITS:0]                len2,
  output logic [2*COORD_BITS:0]                cross_abs
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;
  localparam int SW = 2 * COORD_BITS + 1;
  localparam int T2 = 2 * psd_pkg::TOL_BITS;

  logic signed [DW-1:0] apx_r, apy_r, epx_r, epy_r, aex_r, aey_r;
  logic signed [PW-1:0] p_apx_r, p_apy_r, p_epx_r, p_epy_r, p_aex_r, p_aey_r;
  logic signed [PW-1:0] p_t1_r, p_t2_r, p_c1_r, p_c2_r;
  logic [SW-1:0]        ds2_r, de2_r, len2_r;
  logic signed [PW-1:0] dot_r, cr_r;
  logic [T2-1:0]        tol2_r, deg2_r;

  logic                 near_s, near_e, degen, beyond;
  psd_pkg::case_code_t  code_nxt;
  logic [SW-1:0]        rad_nxt, cr_abs_nxt;
  psd_pkg::case_code_t  code_r;
  logic [SW-1:0]        rad_r, len2_o_r, cr_abs_r;

  // Squared tolerances follow the registers
  always_ff @(posedge clk) begin
    tol2_r <= snap_tol * snap_tol;
    deg2_r <= degen_len * degen_len;
  end

  // Stage 1: coordinate differences
  always_ff @(posedge clk) begin
    if (en) begin
      apx_r <= $signed({query_x[COORD_BITS-1], query_x}) - $signed({start_x[COORD_BITS-1], start_x});
      apy_r <= $signed({query_y[COORD_BITS-1], query_y}) - $signed({start_y[COORD_BITS-1], start_y});
      epx_r <= $signed({query_x[COORD_BITS-1], query_x}) - $signed({end_x[COORD_BITS-1], end_x});
      epy_r <= $signed({query_y[COORD_BITS-1], query_y}) - $signed({end_y[COORD_BITS-1], end_y});
      aex_r <= $signed({end_x[COORD_BITS-1], end_x}) - $signed({start_x[COORD_BITS-1], start_x});
      aey_r <= $signed({end_y[COORD_BITS-1], end_y}) - $signed({start_y[COORD_BITS-1], start_y});
    end
  end

  // Stage 2: products
  always_ff @(posedge clk) begin
    if (en) begin
      p_apx_r <= apx_r * apx_r;
      p_apy_r <= apy_r * apy_r;
      p_epx_r <= epx_r * epx_r;
      p_epy_r <= epy_r * epy_r;
      p_aex_r <= aex_r * aex_r;
      p_aey_r <= aey_r * aey_r;
      p_t1_r  <= aex_r * apx_r;
      p_t2_r  <= aey_r * apy_r;
      p_c1_r  <= apx_r * aey_r;
      p_c2_r  <= apy_r * aex_r;
    end
  end

  // Stage 3: squared distances, dot and cross products
  always_ff @(posedge clk) begin
    if (en) begin
      ds2_r  <= SW'(p_apx_r + p_apy_r);
      de2_r  <= SW'(p_epx_r + p_epy_r);
      len2_r <= SW'(p_aex_r + p_aey_r);
      dot_r  <= p_t1_r + p_t2_r;
      cr_r   <= p_c1_r - p_c2_r;
    end
  end

  // Stage 4: pick the case and the value to take the root of
  always_comb begin
    near_s = ds2_r < SW'(tol2_r);
    near_e = de2_r < SW'(tol2_r);
    degen  = (len2_r < SW'(deg2_r)) || (len2_r == '0);
    beyond = dot_r[PW-1] || (len2_r < SW'(dot_r));
    cr_abs_nxt = cr_r[PW-1] ? SW'(-cr_r) : SW'(cr_r);
    rad_nxt = (de2_r < ds2_r) ? de2_r : ds2_r;
    if (near_s) begin
      code_nxt = psd_pkg::CASE_NEAR_START;
      rad_nxt  = ds2_r;
    end else if (near_e) begin
      code_nxt = psd_pkg::CASE_NEAR_END;
      rad_nxt  = de2_r;
    end else if (degen) begin
      code_nxt = psd_pkg::CASE_DEGEN;
    end else if (beyond) begin
      code_nxt = psd_pkg::CASE_BEYOND;
    end else begin
      code_nxt = psd_pkg::CASE_PERP;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code_r   <= code_nxt;
      rad_r    <= rad_nxt;
      len2_o_r <= len2_r;
      cr_abs_r <= cr_abs_nxt;
    end
  end

  assign code      = code_r;
  assign radicand  = rad_r;
  assign len2      = len2_o_r;
  assign cross_abs = cr_abs_r;

endmodule

`default_nettype wire

// ===== hw/rtl/psd_sqrt.sv =====
// ----------------------------------------------------------------------------
// psd_sqrt
// Pipelined truncating integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_sqrt #(
  parameter int RB = 33
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [2*RB-1:0] radicand,
  output logic      [RB-1:0]   root
);

  localparam int NB = 2 * RB;
  localparam int RW = RB + 3;

  logic [NB-1:0] n_r    [RB];
  logic [RW-1:0] rem_r  [RB];
  logic [RB-1:0] root_r [RB];

  for (genvar i = 0; i < RB; i++) begin : g_stage
    logic [NB-1:0] n_in;
    logic [RW-1:0] rem_in;
    logic [RB-1:0] root_in;
    logic [RW-1:0] rem_cat, trial;
    logic          take;

    if (i == 0) begin : g_first
      assign n_in    = radicand;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign n_in    = n_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
    end

    // Bring down the next bit pair and try the trial divisor
    assign rem_cat = {rem_in[RW-3:0], n_in[NB-1 -: 2]};
    assign trial   = {1'b0, root_in, 2'b01};
    assign take    = rem_cat >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i]    <= {n_in[NB-3:0], 2'b00};
        rem_r[i]  <= take ? (rem_cat - trial) : rem_cat;
        root_r[i] <= {root_in[RB-2:0], take};
      end
    end
  end

  assign root = root_r[RB-1];

endmodule

`default_nettype wire

// ===== hw/rtl/psd_div.sv =====
// ----------------------------------------------------------------------------
// psd_div
// Pipelined restoring divider with saturation, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_div #(
  parameter int QB = 33
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [2*QB-2:0]   num,
  input  wire logic [QB-1:0]     den,
  output logic      [QB-1:0]     quot
);

  localparam int NW = 2 * QB - 1;

  logic [QB-1:0] rem_r  [QB+1];
  logic [QB-1:0] low_r  [QB+1];
  logic [QB-1:0] den_r  [QB+1];
  logic [QB-1:0] q_r    [QB+1];
  logic          over_r [QB+1];

  logic          over0;

  // Prep stage: quotient too wide for the field saturates
  assign over0 = {1'b0, num[NW-1:QB]} >= den;

  always_ff @(posedge clk) begin
    if (en) begin
      over_r[0] <= over0;
      rem_r[0]  <= over0 ? '0 : {1'b0, num[NW-1:QB]};
      low_r[0]  <= num[QB-1:0];
      den_r[0]  <= den;
      q_r[0]    <= '0;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [QB:0] rem_cat;
    logic        take;

    assign rem_cat = {rem_r[k-1], low_r[k-1][QB-1]};
    assign take    = rem_cat >= {1'b0, den_r[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? QB'(rem_cat - {1'b0, den_r[k-1]}) : rem_cat[QB-1:0];
        low_r[k]  <= {low_r[k-1][QB-2:0], 1'b0};
        den_r[k]  <= den_r[k-1];
        q_r[k]    <= {q_r[k-1][QB-2:0], take};
        over_r[k] <= over_r[k-1];
      end
    end
  end

  assign quot = over_r[QB] ? '1 : q_r[QB];

endmodule

`default_nettype wire

// ===== hw/rtl/point_segment_distance.sv =====
// ----------------------------------------------------------------------------
// point_segment_distance
// Distance from a query point to a configured 2-D segment, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Write the segment end points and the two tolerances on the cfg_ port
//   (cfg_we, cfg_index, cfg_data) while no item is in flight.
//   Each item on the in_ channel is a query point; each item on the out_
//   channel is its distance (unsigned integer in coordinate units, saturating) and a case code.
//   Both channels move an item when valid is high and stall is low.
// Pipeline: four front stages, one stage per root bit of the square roots,
//   a prep stage plus one stage per quotient bit of the divider, and the
//   output register.
// Throughput: one item per cycle while no stall holds; every stage is a
//   register step of at most one multiplier or one wide add and compare.
// Stall: while out_stall holds a valid result, the whole pipeline freezes
//   and in_stall is raised; nothing is lost or repeated.
// Reset: synchronous, active low; clears all valid bits and loads the
//   registers with a zero segment, snap tolerance 7, degenerate length 1.
// ----------------------------------------------------------------------------
`default_nettype none

module point_segment_distance #(
  parameter int COORD_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [psd_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [COORD_BITS-1:0]         cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_BITS-1:0]  in_query_x,
  input  wire logic signed [COORD_BITS-1:0]  in_query_y,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [COORD_BITS:0]                out_distance,
  output logic [2:0]                         out_case_code
);

  localparam int DW  = COORD_BITS + 1;
  localparam int SW  = 2 * COORD_BITS + 1;
  localparam int RB  = COORD_BITS + 1;
  localparam int QB  = COORD_BITS + 1;
  localparam int LAT = psd_pkg::FRONT_LAT + RB + QB + 1;

  logic signed [COORD_BITS-1:0]    start_x_r, start_y_r, end_x_r, end_y_r;
  logic [psd_pkg::TOL_BITS-1:0]    snap_r, degen_r;

  logic                  en;
  logic                  vld_d;
  psd_pkg::case_code_t   f_code;
  logic [SW-1:0]         f_rad, f_len2, f_cr;
  logic [RB-1:0]         root_m, root_len;
  psd_pkg::case_code_t   s_code;
  logic [SW-1:0]         s_cr;
  logic [QB-1:0]         quot;
  psd_pkg::case_code_t   d_code;
  logic [RB-1:0]         d_root;

  logic                  out_valid_r;
  logic [DW-1:0]         dist_r, dist_nxt;
  psd_pkg::case_code_t   code_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
      end_x_r   <= '0;
      end_y_r   <= '0;
      snap_r    <= psd_pkg::SNAP_TOL_RESET;
      degen_r   <= psd_pkg::DEGEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        psd_pkg::REG_START_X:  start_x_r <= cfg_data;
        psd_pkg::REG_START_Y:  start_y_r <= cfg_data;
        psd_pkg::REG_END_X:    end_x_r   <= cfg_data;
        psd_pkg::REG_END_Y:    end_y_r   <= cfg_data;
        psd_pkg::REG_SNAP_TOL: snap_r    <= cfg_data[psd_pkg::TOL_BITS-1:0];
        psd_pkg::REG_DEGEN:    degen_r   <= cfg_data[psd_pkg::TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless a held result is stalled
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  psd_delay #(.WIDTH(1), .DEPTH(LAT)) u_valid (
    .clk(clk), .rst_n(rst_n), .en(en), .din(in_valid), .dout(vld_d)
  );

  psd_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .en(en),
    .query_x(in_query_x), .query_y(in_query_y),
    .start_x(start_x_r), .start_y(start_y_r),
    .end_x(end_x_r), .end_y(end_y_r),
    .snap_tol(snap_r), .degen_len(degen_r),
    .code(f_code), .radicand(f_rad), .len2(f_len2), .cross_abs(f_cr)
  );

  // Roots of the chosen squared distance and of the squared length
  psd_sqrt #(.RB(RB)) u_sqrt_dist (
    .clk(clk), .en(en), .radicand({1'b0, f_rad}), .root(root_m)
  );

  psd_sqrt #(.RB(RB)) u_sqrt_len (
    .clk(clk), .en(en), .radicand({1'b0, f_len2}), .root(root_len)
  );

  psd_delay #(.WIDTH(3 + SW), .DEPTH(RB)) u_align_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .din({f_code, f_cr}), .dout({s_code, s_cr})
  );

  psd_div #(.QB(QB)) u_div (
    .clk(clk), .en(en), .num(s_cr), .den(root_len), .quot(quot)
  );

  psd_delay #(.WIDTH(3 + RB), .DEPTH(QB + 1)) u_align_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .din({s_code, root_m}), .dout({d_code, d_root})
  );

  // Select the distance for the case
  always_comb begin
    case (d_code)
      psd_pkg::CASE_PERP:  dist_nxt = quot;
      psd_pkg::CASE_DEGEN: dist_nxt = '1;
      default:             dist_nxt = d_root;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= dist_nxt;
      code_r <= d_code;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_distance  = dist_r;
  assign out_case_code = code_r;

  // The degenerate case always reports the maximum distance
  a_degen_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_case_code == psd_pkg::CASE_DEGEN |-> &out_distance)
    else $error("degenerate case without maximum distance");

  // A beyond-the-ends distance never reaches the saturation value
  a_beyond_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_case_code == psd_pkg::CASE_BEYOND |-> !(&out_distance))
    else $error("endpoint root out of range");

  // Reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid result after reset");

endmodule

`default_nettype wire

// ===== test/point_segment_distance_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_distance_tb
// Self-checking bench for the point-to-segment distance pipeline. A driver
// sends query points from a queue, a monitor compares each result with a
// distance predicted at acceptance time, over several segment settings and
// several patterns of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
`default_nettype none

module point_segment_distance_tb;

  localparam logic [32:0] DIST_ALL_ONES = 33'h1_FFFF_FFFF;
  localparam int TIMEOUT_CYCLES = 2000000;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int NUM_PHASES = 8;

  typedef struct packed {
    logic [31:0] qx;
    logic [31:0] qy;
  } query_t;

  typedef struct packed {
    logic [32:0]         distance;
    psd_pkg::case_code_t code;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [psd_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_query_x = '0;
  logic signed [31:0] in_query_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [32:0] out_distance;
  logic [2:0] out_case_code;

  // Segment copy held by the bench
  logic [31:0] seg_sx, seg_sy, seg_ex, seg_ey;
  logic [15:0] snap_tol, degen_len;

  query_t  pending_queries[$];
  answer_t expected_answers[$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int cycles = 0;
  bit item_taken = 1'b0;

  point_segment_distance u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_query_x(in_query_x), .in_query_y(in_query_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_distance(out_distance), .out_case_code(out_case_code)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Truncating integer square root
  function automatic logic [63:0] int_sqrt(input logic [127:0] n);
    logic [63:0] root;
    logic [127:0] cand;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = {64'd0, root | (64'd1 << b)};
      if (cand * cand <= n) root = cand[63:0];
    end
    return root;
  endfunction

  function automatic logic [32:0] clamp_dist(input logic [127:0] v);
    return (v > {95'd0, DIST_ALL_ONES}) ? DIST_ALL_ONES : v[32:0];
  endfunction

  // Distance and case for one query against the current segment
  function automatic answer_t segment_distance(input query_t q);
    longint qx, qy, sx, sy, ex, ey;
    logic signed [127:0] apx, apy, epx, epy, aex, aey, t, cr;
    logic [127:0] ds2, de2, len2, tol2, deg2, root;
    answer_t a;
    qx = longint'($signed(q.qx));
    qy = longint'($signed(q.qy));
    sx = longint'($signed(seg_sx));
    sy = longint'($signed(seg_sy));
    ex = longint'($signed(seg_ex));
    ey = longint'($signed(seg_ey));
    apx = qx - sx; apy = qy - sy;
    epx = qx - ex; epy = qy - ey;
    aex = ex - sx; aey = ey - sy;
    ds2 = apx * apx + apy * apy;
    de2 = epx * epx + epy * epy;
    len2 = aex * aex + aey * aey;
    tol2 = {112'd0, snap_tol} * {112'd0, snap_tol};
    deg2 = {112'd0, degen_len} * {112'd0, degen_len};
    if (ds2 < tol2) begin
      a.distance = clamp_dist({64'd0, int_sqrt(ds2)});
      a.code = psd_pkg::CASE_NEAR_START;
    end else if (de2 < tol2) begin
      a.distance = clamp_dist({64'd0, int_sqrt(de2)});
      a.code = psd_pkg::CASE_NEAR_END;
    end else if (len2 < deg2 || len2 == 0) begin
      a.distance = DIST_ALL_ONES;
      a.code = psd_pkg::CASE_DEGEN;
    end else begin
      t = aex * apx + aey * apy;
      if (t < 0 || $unsigned(t) > len2) begin
        a.distance = clamp_dist({64'd0, int_sqrt((de2 < ds2) ? de2 : ds2)});
        a.code = psd_pkg::CASE_BEYOND;
      end else begin
        cr = apx * aey - apy * aex;
        if (cr < 0) cr = -cr;
        root = {64'd0, int_sqrt(len2)};
        a.distance = clamp_dist($unsigned(cr) / root);
        a.code = psd_pkg::CASE_PERP;
      end
    end
    return a;
  endfunction

  // Write one register while the block is idle, and track it
  task automatic write_reg(input psd_pkg::cfg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      psd_pkg::REG_START_X:  seg_sx = data;
      psd_pkg::REG_START_Y:  seg_sy = data;
      psd_pkg::REG_END_X:    seg_ex = data;
      psd_pkg::REG_END_Y:    seg_ey = data;
      psd_pkg::REG_SNAP_TOL: snap_tol = data[15:0];
      psd_pkg::REG_DEGEN:    degen_len = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_query(input longint x, input longint y);
    query_t q;
    q.qx = x[31:0];
    q.qy = y[31:0];
    pending_queries.push_back(q);
  endtask

  // Random query, mostly near the segment and its ends
  task automatic push_random_query();
    longint sx, sy, ex, ey, f, off;
    int mode;
    sx = longint'($signed(seg_sx));
    sy = longint'($signed(seg_sy));
    ex = longint'($signed(seg_ex));
    ey = longint'($signed(seg_ey));
    mode = $urandom_range(0, 9);
    off = longint'($urandom_range(0, 1 << $urandom_range(0, 20)));
    if ($urandom_range(0, 1)) off = -off;
    case (mode)
      0, 1: push_query($urandom, $urandom);
      2: push_query(sx + $signed($urandom_range(0, 2 * snap_tol)) - snap_tol,
                    sy + $signed($urandom_range(0, 2 * snap_tol)) - snap_tol);
      3: push_query(ex + $signed($urandom_range(0, 2 * snap_tol)) - snap_tol,
                    ey + $signed($urandom_range(0, 2 * snap_tol)) - snap_tol);
      9: begin
        f = longint'($urandom_range(0, 2048)) - 512;
        push_query(sx + ((ex - sx) * f) / 1024 + off, sy + ((ey - sy) * f) / 1024 - off);
      end
      default: begin
        f = longint'($urandom_range(0, 1024));
        push_query(sx + ((ex - sx) * f) / 1024 + off, sy + ((ey - sy) * f) / 1024 + off);
      end
    endcase
  endtask

  // Wait until every item is sent and every result is back
  task automatic drain();
    do @(posedge clk);
    while (pending_queries.size() != 0 || in_valid || expected_answers.size() != 0);
  endtask

  task automatic set_segment(input logic [31:0] sx, input logic [31:0] sy,
                             input logic [31:0] ex, input logic [31:0] ey,
                             input logic [31:0] tol, input logic [31:0] deg);
    write_reg(psd_pkg::REG_START_X, sx);
    write_reg(psd_pkg::REG_START_Y, sy);
    write_reg(psd_pkg::REG_END_X, ex);
    write_reg(psd_pkg::REG_END_Y, ey);
    write_reg(psd_pkg::REG_SNAP_TOL, tol);
    write_reg(psd_pkg::REG_DEGEN, deg);
  endtask

  // Driver: present the next item or idle, hold a stalled item
  always @(negedge clk) begin
    if (rst_n && (!in_valid || item_taken)) begin
      if (pending_queries.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        query_t q;
        q = pending_queries.pop_front();
        in_valid <= 1'b1;
        in_query_x <= q.qx;
        in_query_y <= q.qy;
      end else begin
        in_valid <= 1'b0;
      end
    end
    item_taken = 1'b0;
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Monitor: predict on input acceptance, check on output acceptance
  always @(posedge clk) begin
    answer_t exp_a;
    query_t q;
    cycles <= cycles + 1;
    if (rst_n && in_valid && !in_stall) begin
      q.qx = in_query_x;
      q.qy = in_query_y;
      expected_answers.push_back(segment_distance(q));
      item_taken = 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: distance %h case %0d", out_distance, out_case_code);
      end else begin
        exp_a = expected_answers.pop_front();
        if (out_distance !== exp_a.distance || out_case_code !== exp_a.code) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: distance exp %h got %h, case exp %0d got %0d",
                     exp_a.distance, out_distance, exp_a.code, out_case_code);
        end
      end
    end
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    if (cycles > TIMEOUT_CYCLES) begin
      $display("point_segment_distance regression: fail");
      $finish;
    end
  end

  initial begin
    seg_sx = '0; seg_sy = '0; seg_ex = '0; seg_ey = '0;
    snap_tol = psd_pkg::SNAP_TOL_RESET;
    degen_len = psd_pkg::DEGEN_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset segment: zero length, snap around the origin
    push_query(0, 0);
    push_query(6, 0);
    push_query(7, 0);
    push_query(4, 5);
    push_query(32'h8000_0000, 32'h8000_0000);
    push_query(32'h7FFF_FFFF, 32'h8000_0000);
    drain();

    // Horizontal segment: perpendicular, beyond, near ends, tie
    set_segment(32'h0000_0000, 32'h0000_0000, 32'h000A_0000, 32'h0000_0000, 100, 1);
    push_query(32'h0005_0000, 32'h0003_0000);
    push_query(32'h0005_0000, -32'h0003_0000);
    push_query(-32'h0001_0000, 32'h0001_0000);
    push_query(32'h000B_0000, 32'h0001_0000);
    push_query(5, 5);
    push_query(32'h000A_0003, 3);
    push_query(32'h0005_0000, 32'h7FFF_FFFF);
    push_query(32'h0005_0000, 32'h8000_0000);
    push_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain();

    // Extreme segment and tolerances, ignored index
    set_segment(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'hFFFF_FFFF, 32'hABCD_0000);
    write_reg(psd_pkg::cfg_idx_t'(6), 32'h1234_5678);
    write_reg(psd_pkg::cfg_idx_t'(7), 32'h0000_0000);
    push_query(32'h8000_0000, 32'h7FFF_FFFF);
    push_query(32'h7FFF_FFFF, 32'h8000_0000);
    push_query(0, 0);
    push_query(32'h8000_FFFF, 32'h8000_0000);
    drain();

    // Zero length with no degenerate floor; long length below the floor
    set_segment(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 0, 0);
    push_query(32'h0100_0000, 32'h0100_0000);
    push_query(32'h0200_0000, 32'h0100_0000);
    drain();
    set_segment(0, 0, 32'd40000, 0, 3, 32'd65535);
    push_query(32'd20000, 32'd50);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 56; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 56; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      case (p)
        0: set_segment($urandom, $urandom, $urandom, $urandom,
                       $urandom_range(0, 65535), $urandom_range(0, 65535));
        3: set_segment(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'd65535, 0);
        5: set_segment(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                       $urandom_range(0, 20), 0);
        default: set_segment($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000,
                             $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000,
                             $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000,
                             $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000,
                             $urandom_range(0, 300), $urandom_range(0, 8));
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) push_random_query();
      drain();
    end

    // Settle past the pipeline latency, then report
    repeat (2 * 32 + 40) @(posedge clk);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("point_segment_distance regression: pass");
    end else begin
      $display("point_segment_distance regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
